### hw/rtl/vp8sq_pkg.sv
// ----------------------------------------------------------------------------
// vp8sq_pkg
// Shared tables, constants and types for the VP8 segment quantizer and loop
// filter parameter block.
// ----------------------------------------------------------------------------
package vp8sq_pkg;

    localparam int IDX_W = 7;

    localparam logic [IDX_W-1:0] IDX_MAX        = 7'd127;
    localparam logic [IDX_W-1:0] LUMA_DC_DELTA  = 7'd15;
    localparam logic [IDX_W-1:0] CHROMA_DELTA   = 7'd15;
    localparam logic [7:0]       CHROMA_DC_CAP  = 8'd132;
    localparam logic [8:0]       SECOND_AC_MIN  = 9'd8;
    localparam logic [5:0]       LEVEL_MAX      = 6'd63;
    localparam logic [3:0]       INTERIOR_BASE  = 4'd9;
    localparam logic [2:0]       SHARP_COARSE   = 3'd4;
    localparam logic [5:0]       HEV_HIGH       = 6'd40;
    localparam logic [5:0]       HEV_MID_INTER  = 6'd20;
    localparam logic [5:0]       HEV_LOW        = 6'd15;

    // 31/20 scaling: the quotient by 5 is a multiply by ceil(2^14/5), exact
    // for dividends below 2^14
    localparam logic [11:0]      DIV5_RECIP     = 12'd3277;

    typedef enum logic [1:0] {
        CFG_MIN_QUANT = 2'd0,
        CFG_SHARPNESS = 2'd1
    } cfg_reg_t;

    typedef struct packed {
        logic [5:0] level;
        logic [5:0] interior;
        logic [7:0] mb_edge;
        logic [7:0] sub_edge;
        logic [1:0] hev;
    } lf_params_t;

    localparam logic [7:0] DC_TAB [0:127] = '{
        4, 5, 6, 7, 8, 9, 10, 10, 11, 12, 13, 14, 15, 16, 17,
        17, 18, 19, 20, 20, 21, 21, 22, 22, 23, 23, 24, 25, 25, 26,
        27, 28, 29, 30, 31, 32, 33, 34, 35, 36, 37, 37, 38, 39, 40,
        41, 42, 43, 44, 45, 46, 46, 47, 48, 49, 50, 51, 52, 53, 54,
        55, 56, 57, 58, 59, 60, 61, 62, 63, 64, 65, 66, 67, 68, 69,
        70, 71, 72, 73, 74, 75, 76, 76, 77, 78, 79, 80, 81, 82, 83,
        84, 85, 86, 87, 88, 89, 91, 93, 95, 96, 98, 100, 101, 102, 104,
        106, 108, 110, 112, 114, 116, 118, 122, 124, 126, 128, 130, 132, 134, 136,
        138, 140, 143, 145, 148, 151, 154, 157
    };

    localparam logic [8:0] AC_TAB [0:127] = '{
        4, 5, 6, 7, 8, 9, 10, 11, 12, 13, 14, 15, 16, 17, 18,
        19, 20, 21, 22, 23, 24, 25, 26, 27, 28, 29, 30, 31, 32, 33,
        34, 35, 36, 37, 38, 39, 40, 41, 42, 43, 44, 45, 46, 47, 48,
        49, 50, 51, 52, 53, 54, 55, 56, 57, 58, 60, 62, 64, 66, 68,
        70, 72, 74, 76, 78, 80, 82, 84, 86, 88, 90, 92, 94, 96, 98,
        100, 102, 104, 106, 108, 110, 112, 114, 116, 119, 122, 125, 128, 131, 134,
        137, 140, 143, 146, 149, 152, 155, 158, 161, 164, 167, 170, 173, 177, 181,
        185, 189, 193, 197, 201, 205, 209, 213, 217, 221, 225, 229, 234, 239, 245,
        249, 254, 259, 264, 269, 274, 279, 284
    };

endpackage

### hw/rtl/vp8sq_lf_params.sv
// ----------------------------------------------------------------------------
// vp8sq_lf_params
// Loop filter level, interior and edge limits and HEV threshold from the
// luma DC step, the frame type and the sharpness setting.
// ----------------------------------------------------------------------------
module vp8sq_lf_params
    import vp8sq_pkg::*;
#(
    parameter int LEVEL_DIVISOR = 4
)
(
    input  logic [7:0]  luma_dc,
    input  logic        key,
    input  logic [2:0]  sharpness,
    output lf_params_t  params
);

    // a zero divisor behaves as one
    localparam int DIV_EFF     = (LEVEL_DIVISOR > 0) ? LEVEL_DIVISOR : 1;
    localparam int RECIP_SHIFT = 16;
    localparam logic [16:0] LEVEL_RECIP =
        17'(((1 << RECIP_SHIFT) + DIV_EFF - 1) / DIV_EFF);

    logic [24:0] level_prod;
    logic [7:0]  level_quot;
    logic [5:0]  level;
    logic [5:0]  shifted;
    logic [3:0]  cap;
    logic [5:0]  interior;
    logic [1:0]  hev;

    // reciprocal multiply is exact for an 8-bit dividend and divisor up to 16
    assign level_prod = {17'd0, luma_dc} * {8'd0, LEVEL_RECIP};
    assign level_quot = level_prod[RECIP_SHIFT+7:RECIP_SHIFT];
    assign level      = (level_quot > {2'd0, LEVEL_MAX}) ? LEVEL_MAX : level_quot[5:0];

    assign cap = INTERIOR_BASE - {1'b0, sharpness};

    always_comb
    begin
        interior = level;
        shifted  = (sharpness > SHARP_COARSE) ? (level >> 2) : (level >> 1);
        if (sharpness != 3'd0)
        begin
            interior = (shifted > {2'd0, cap}) ? {2'd0, cap} : shifted;
        end
        if (interior == 6'd0)
        begin
            interior = 6'd1;
        end
    end

    always_comb
    begin
        hev = 2'd0;
        if (key)
        begin
            if (level >= HEV_HIGH)
                hev = 2'd2;
            else if (level >= HEV_LOW)
                hev = 2'd1;
        end
        else
        begin
            if (level >= HEV_HIGH)
                hev = 2'd3;
            else if (level >= HEV_MID_INTER)
                hev = 2'd2;
            else if (level >= HEV_LOW)
                hev = 2'd1;
        end
    end

    assign params.level    = level;
    assign params.interior = interior;
    assign params.mb_edge  = {1'b0, level, 1'b0} + 8'd4 + {2'd0, interior};
    assign params.sub_edge = {1'b0, level, 1'b0} + {2'd0, interior};
    assign params.hev      = hev;

endmodule

### hw/rtl/vp8_segment_quant_filter_params.sv
// ----------------------------------------------------------------------------
// vp8_segment_quant_filter_params
// Per-segment VP8 dequantization factors and loop filter settings.
//
//   channel   handshake              payload
//   -------   --------------------   ------------------------------------------
//   command   start, busy            is_key, is_altref, last_quant_index,
//                                    altref_quant_index
//   result    done (one cycle)       chosen_index .. hev_thresh
//   config    cfg_wr_en, cfg_index   cfg_data
//
// One segment enters per cycle; busy is always low. Each result passes index
// select and clamp, table lookup, then the reciprocal multiplies and filter
// limits, each registered, before it appears on done.
// Reset clears the configuration registers and the stage valid bits.
// The receiver cannot stall; results are never held.
// ----------------------------------------------------------------------------
module vp8_segment_quant_filter_params
    import vp8sq_pkg::*;
#(
    parameter int LEVEL_DIVISOR = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [6:0]  cfg_data,
    input  logic        start,
    output logic        busy,
    input  logic        is_key,
    input  logic        is_altref,
    input  logic [6:0]  last_quant_index,
    input  logic [6:0]  altref_quant_index,
    output logic        done,
    output logic [6:0]  chosen_index,
    output logic [8:0]  luma_ac_step,
    output logic [7:0]  luma_dc_step,
    output logic [8:0]  second_dc_step,
    output logic [8:0]  second_ac_step,
    output logic [7:0]  chroma_dc_step,
    output logic [8:0]  chroma_ac_step,
    output logic [5:0]  filter_level,
    output logic [5:0]  inner_limit,
    output logic [7:0]  mb_edge_limit,
    output logic [7:0]  sub_edge_limit,
    output logic [1:0]  hev_thresh
);

    logic [6:0] min_quant_reg;
    logic [2:0] sharpness_reg;

    logic       accept;
    logic [6:0] idx_next;
    logic [7:0] ydc_sum;
    logic [6:0] ydc_idx_next;
    logic [6:0] uv_idx_next;

    logic       s1_valid_reg;
    logic       s1_key_reg;
    logic [6:0] s1_idx_reg;
    logic [6:0] s1_ydc_idx_reg;
    logic [6:0] s1_uv_idx_reg;

    logic       s2_valid_reg;
    logic       s2_key_reg;
    logic [6:0] s2_idx_reg;
    logic [8:0] s2_yac_reg;
    logic [7:0] s2_ydc_reg;
    logic [8:0] s2_y2dc_reg;
    logic [7:0] s2_uvdc_reg;
    logic [8:0] s2_uvac_reg;

    logic [7:0]  uvdc_raw;
    logic [13:0] yac_x31;
    logic [11:0] yac_quarter;
    logic [23:0] y2ac_prod;
    logic [8:0]  y2ac_quot;
    logic [8:0]  y2ac_next;
    lf_params_t  lf;

    logic       done_reg;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_quant_reg <= '0;
            sharpness_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_MIN_QUANT: min_quant_reg <= cfg_data;
                CFG_SHARPNESS: sharpness_reg <= cfg_data[2:0];
                default:       ;
            endcase
        end
    end

    // stage 1: pick the index and clamp the adjusted ones
    assign idx_next     = is_key ? min_quant_reg
                                 : (is_altref ? altref_quant_index : last_quant_index);
    assign ydc_sum      = {1'b0, idx_next} + {1'b0, LUMA_DC_DELTA};
    assign ydc_idx_next = (ydc_sum > {1'b0, IDX_MAX}) ? IDX_MAX : ydc_sum[6:0];
    assign uv_idx_next  = is_key ? idx_next
                        : ((idx_next < CHROMA_DELTA) ? 7'd0 : idx_next - CHROMA_DELTA);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= accept;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_key_reg     <= is_key;
            s1_idx_reg     <= idx_next;
            s1_ydc_idx_reg <= ydc_idx_next;
            s1_uv_idx_reg  <= uv_idx_next;
        end
    end

    // stage 2: table lookups, with the chroma DC cap and the doubled Y2 DC step
    assign uvdc_raw = DC_TAB[s1_uv_idx_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            s2_key_reg  <= s1_key_reg;
            s2_idx_reg  <= s1_idx_reg;
            s2_yac_reg  <= AC_TAB[s1_idx_reg];
            s2_ydc_reg  <= DC_TAB[s1_ydc_idx_reg];
            s2_y2dc_reg <= {DC_TAB[s1_idx_reg], 1'b0};
            s2_uvdc_reg <= (uvdc_raw > CHROMA_DC_CAP) ? CHROMA_DC_CAP : uvdc_raw;
            s2_uvac_reg <= AC_TAB[s1_uv_idx_reg];
        end
    end

    // stage 3: 31/20 scaling as x31, drop two bits, then divide by 5
    assign yac_x31     = {s2_yac_reg, 5'd0} - {5'd0, s2_yac_reg};
    assign yac_quarter = yac_x31[13:2];
    assign y2ac_prod   = {12'd0, yac_quarter} * {12'd0, DIV5_RECIP};
    assign y2ac_quot   = y2ac_prod[22:14];
    assign y2ac_next   = (y2ac_quot < SECOND_AC_MIN) ? SECOND_AC_MIN : y2ac_quot;

    vp8sq_lf_params #(
        .LEVEL_DIVISOR (LEVEL_DIVISOR)
    ) u_lf_params (
        .luma_dc   (s2_ydc_reg),
        .key       (s2_key_reg),
        .sharpness (sharpness_reg),
        .params    (lf)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= s2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s2_valid_reg)
        begin
            chosen_index   <= s2_idx_reg;
            luma_ac_step   <= s2_yac_reg;
            luma_dc_step   <= s2_ydc_reg;
            second_dc_step <= s2_y2dc_reg;
            second_ac_step <= y2ac_next;
            chroma_dc_step <= s2_uvdc_reg;
            chroma_ac_step <= s2_uvac_reg;
            filter_level   <= lf.level;
            inner_limit    <= lf.interior;
            mb_edge_limit  <= lf.mb_edge;
            sub_edge_limit <= lf.sub_edge;
            hev_thresh     <= lf.hev;
        end
    end

    assign done = done_reg;

    // every result beat traces back to an accepted start beat through the stage registers
    a_done_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 3))
        else $error("result beat without matching start beat");

    a_edge_gap: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (mb_edge_limit == sub_edge_limit + 8'd4))
        else $error("edge limits inconsistent");

    a_interior_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (inner_limit != 6'd0))
        else $error("interior limit is zero");

    a_second_ac_floor: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (second_ac_step >= SECOND_AC_MIN))
        else $error("Y2 AC step below floor");

endmodule
